// ===== sv/csb_pkg.sv =====
// Package for the cursor sequence buffer: operation codes, error codes and
// the command that steers a chain of storage cells. No dependencies.
package csb_pkg;

  localparam int OP_BITS  = 3;
  localparam int ERR_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_START   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_ADVANCE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_INSERT  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_ATTACH  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_REMOVE  = 3'd4;

  localparam logic [ERR_BITS-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_FULL   = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_NO_CUR = 2'd2;

  // What every cell of a chain does under each command. PUSH moves all words one
  // place away from the head and takes a new head word, POP moves them one
  // place towards the head, LOAD replaces the head word alone.
  typedef enum logic [1:0] {
    CH_HOLD,
    CH_PUSH,
    CH_POP,
    CH_LOAD
  } chain_cmd_t;

endpackage

// ===== sv/cursor_sequence_buffer_unit.sv =====
// Top level of the cursor sequence buffer: control sequencer and two cell
// chains. Depends on csb_pkg, csb_chain and csb_cell.
//
// The buffer holds up to CAPACITY words as a gap buffer made of two stacks of
// cells: the left chain holds the entries before the cursor with the nearest
// one at its head, and the right chain holds the current entry at its head
// followed by the rest of the list. An operation is transferred at a rising
// edge where start is high and busy is low. Advance, insert with a current
// entry, attach and remove shift the chains by one place in that same cycle,
// and the result strobe out_valid is high for the single following cycle.
// Start, and insert when there is no current entry, must bring the cursor to
// the front: busy then stays high while the left chain empties into the right
// one a word per cycle, and out_valid rises in the same cycle that busy falls.
// The receiver cannot hold results off: each result is on the out_ ports for
// exactly one cycle and must be taken then. A new operation may be transferred
// during that strobe cycle.
// A full buffer rejects insert and attach with an error and leaves the list
// unchanged; a remove with no current entry is rejected likewise.
module cursor_sequence_buffer_unit #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [csb_pkg::OP_BITS-1:0]   in_op,
  input  logic [31:0]                   in_word_in,
  output logic                          out_valid,
  output logic                          out_has_current,
  output logic [31:0]                   out_current_word,
  output logic [4:0]                    out_entry_count,
  output logic [csb_pkg::ERR_BITS-1:0]  out_error_code
);
  import csb_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REWIND = 1'b1;

  logic                 state_r, state_nxt;
  logic [CW-1:0]        lcount_r, lcount_nxt;
  logic [CW-1:0]        rcount_r, rcount_nxt;
  logic [ERR_BITS-1:0]  err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 pend_ins_r, pend_ins_nxt;
  logic [WORD_BITS-1:0] word_r;

  chain_cmd_t           l_cmd, r_cmd;
  logic [WORD_BITS-1:0] l_head, r_head;
  logic [WORD_BITS-1:0] r_head_in;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS+31:0] word_ext;
  logic [WORD_BITS+31:0] cur_ext;
  logic [CW-1:0]        total;
  logic [CW+4:0]        total_ext;
  logic                 accept;
  logic                 full;
  logic                 has_cur;

  // The incoming word is cut or widened to the stored width.
  assign word_ext = {{WORD_BITS{1'b0}}, in_word_in};
  assign word     = word_ext[WORD_BITS-1:0];

  assign accept  = start && (state_r == ST_IDLE);
  assign total   = lcount_r + rcount_r;
  assign full    = (total == CW'(CAPACITY));
  assign has_cur = (rcount_r != '0);

  always_comb begin
    state_nxt     = state_r;
    lcount_nxt    = lcount_r;
    rcount_nxt    = rcount_r;
    err_nxt       = err_r;
    out_valid_nxt = 1'b0;
    pend_ins_nxt  = pend_ins_r;
    l_cmd         = CH_HOLD;
    r_cmd         = CH_HOLD;
    r_head_in     = word;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          err_nxt       = ERR_NONE;
          out_valid_nxt = 1'b1;
          case (in_op)
            OP_START: begin
              state_nxt     = ST_REWIND;
              pend_ins_nxt  = 1'b0;
              out_valid_nxt = 1'b0;
            end
            OP_ADVANCE: begin
              if (has_cur) begin
                // The current word moves over to the left chain.
                l_cmd      = CH_PUSH;
                r_cmd      = CH_POP;
                lcount_nxt = lcount_r + 1'b1;
                rcount_nxt = rcount_r - 1'b1;
              end
            end
            OP_INSERT: begin
              if (full) begin
                err_nxt = ERR_FULL;
              end else if (has_cur) begin
                r_cmd      = CH_PUSH;
                rcount_nxt = rcount_r + 1'b1;
              end else begin
                // The word goes to the front, so the cursor rewinds first.
                state_nxt     = ST_REWIND;
                pend_ins_nxt  = 1'b1;
                out_valid_nxt = 1'b0;
              end
            end
            OP_ATTACH: begin
              if (full) begin
                err_nxt = ERR_FULL;
              end else if (has_cur) begin
                // Old current word steps left; the new word takes its place.
                l_cmd      = CH_PUSH;
                r_cmd      = CH_LOAD;
                lcount_nxt = lcount_r + 1'b1;
              end else begin
                r_cmd      = CH_PUSH;
                rcount_nxt = rcount_r + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (has_cur) begin
                r_cmd      = CH_POP;
                rcount_nxt = rcount_r - 1'b1;
              end else begin
                err_nxt = ERR_NO_CUR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REWIND: begin
        if (lcount_r != '0) begin
          l_cmd      = CH_POP;
          r_cmd      = CH_PUSH;
          r_head_in  = l_head;
          lcount_nxt = lcount_r - 1'b1;
          rcount_nxt = rcount_r + 1'b1;
        end else begin
          if (pend_ins_r) begin
            r_cmd      = CH_PUSH;
            r_head_in  = word_r;
            rcount_nxt = rcount_r + 1'b1;
          end
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lcount_r    <= '0;
      rcount_r    <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
      pend_ins_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcount_r    <= lcount_nxt;
      rcount_r    <= rcount_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      pend_ins_r  <= pend_ins_nxt;
    end
  end

  // The word is kept for an insert that waits behind a rewind.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= word;
    end
  end

  // The left chain always takes its new head from the right chain's head.
  csb_chain #(.DEPTH(CAPACITY), .WORD_BITS(WORD_BITS)) u_left (
    .clk    (clk),
    .cmd    (l_cmd),
    .head_i (r_head),
    .head_o (l_head)
  );

  csb_chain #(.DEPTH(CAPACITY), .WORD_BITS(WORD_BITS)) u_right (
    .clk    (clk),
    .cmd    (r_cmd),
    .head_i (r_head_in),
    .head_o (r_head)
  );

  // Results are read straight from the state, which holds during the strobe.
  assign cur_ext   = {32'd0, r_head};
  assign total_ext = {5'd0, total};

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_has_current  = has_cur;
  assign out_current_word = has_cur ? cur_ext[31:0] : 32'd0;
  assign out_entry_count  = total_ext[4:0];
  assign out_error_code   = err_r;

`ifndef ASSERT_OFF
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, lcount_r} + {1'b0, rcount_r}) <= (CW + 1)'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe while rewinding");

  a_rewind_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REWIND && lcount_r != '0) |=> $stable(total))
    else $error("rewind step changed the entry count");

  a_quick_op_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op != OP_START && !(in_op == OP_INSERT && !full && !has_cur))
    |=> out_valid)
    else $error("single-cycle operation gave no result");

  a_rewind_ends_front: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (lcount_r == '0 && out_valid))
    else $error("rewind finished with cursor away from the front");
`endif

endmodule

// ===== sv/csb_cell.sv =====
// One storage cell of a cursor sequence buffer chain.
// Depends on csb_pkg for the chain command type.
module csb_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  csb_pkg::chain_cmd_t   cmd,
  input  logic [WORD_BITS-1:0]  shallow_i,
  input  logic [WORD_BITS-1:0]  deep_i,
  output logic [WORD_BITS-1:0]  q_o
);
  import csb_pkg::*;

  logic [WORD_BITS-1:0] data_r;
  logic [WORD_BITS-1:0] data_nxt;

  // LOAD only reaches the head cell, where it takes the shallow side input.
  always_comb begin
    case (cmd)
      CH_HOLD: data_nxt = data_r;
      CH_PUSH: data_nxt = shallow_i;
      CH_POP:  data_nxt = deep_i;
      CH_LOAD: data_nxt = shallow_i;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q_o = data_r;

endmodule

// ===== sv/csb_chain.sv =====
// A stack built as a row of csb_cell instances, head at cell zero.
// Depends on csb_pkg and csb_cell.
module csb_chain #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  csb_pkg::chain_cmd_t   cmd,
  input  logic [WORD_BITS-1:0]  head_i,
  output logic [WORD_BITS-1:0]  head_o
);
  import csb_pkg::*;

  logic [WORD_BITS-1:0] q [DEPTH];
  chain_cmd_t           body_cmd;

  // Cells behind the head ignore a LOAD.
  assign body_cmd = (cmd == CH_LOAD) ? CH_HOLD : cmd;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] shallow;
    logic [WORD_BITS-1:0] deep;
    chain_cmd_t           cell_cmd;

    if (i == 0) begin : g_head
      assign shallow  = head_i;
      assign cell_cmd = cmd;
    end else begin : g_body
      assign shallow  = q[i-1];
      assign cell_cmd = body_cmd;
    end

    if (i == DEPTH - 1) begin : g_tail
      assign deep = '0;
    end else begin : g_mid
      assign deep = q[i+1];
    end

    csb_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk       (clk),
      .cmd       (cell_cmd),
      .shallow_i (shallow),
      .deep_i    (deep),
      .q_o       (q[i])
    );
  end

  assign head_o = q[0];

endmodule

// ===== tb/sv/tb_cursor_sequence_buffer_unit.sv =====
// Self-checking testbench for cursor_sequence_buffer_unit. It holds its own model of the list.
// Directed and random operations are driven through the start/busy handshake.
// Every result strobe is checked against the model. Depends on csb_pkg and the unit's RTL.
module tb_cursor_sequence_buffer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import csb_pkg::*;

  localparam int CAPACITY = 16;
  localparam int WORD_BITS = 32;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_OPS = 800;

  // The three shapes that the random phases take: growing the list until it
  // overflows, walking the cursor along it, and draining it again.
  typedef enum int {
    PH_FILL,
    PH_WALK,
    PH_DRAIN
  } phase_kind_t;

  // One operation waiting to go out. A held operation waits until every
  // report that is owed has come back.
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [31:0]        word;
    logic               hold;
  } list_op_t;

  // What the block reports after one operation.
  typedef struct packed {
    logic                has_current;
    logic [31:0]         current_word;
    logic [4:0]          entry_count;
    logic [ERR_BITS-1:0] error_code;
  } list_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [OP_BITS-1:0]  in_op = OP_START;
  logic [31:0]         in_word_in = '0;
  logic                out_valid;
  logic                out_has_current;
  logic [31:0]         out_current_word;
  logic [4:0]          out_entry_count;
  logic [ERR_BITS-1:0] out_error_code;

  cursor_sequence_buffer_unit #(
    .CAPACITY (CAPACITY),
    .WORD_BITS(WORD_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_word_in      (in_word_in),
    .out_valid       (out_valid),
    .out_has_current (out_has_current),
    .out_current_word(out_current_word),
    .out_entry_count (out_entry_count),
    .out_error_code  (out_error_code)
  );

  // Operations still to be driven, and the reports still owed by the block.
  list_op_t     op_queue[$];
  list_report_t owed_reports[$];

  // The testbench's own copy of the list. The cursor equals the count when
  // there is no current entry.
  logic [31:0] list_words[CAPACITY];
  int          list_cursor = 0;
  int          list_count = 0;

  int  fault_count = 0;
  int  report_index = 0;
  bit  took_op = 1'b0;
  int  burst_left = 1;
  int  gap_left = 0;
  list_op_t     launch_op;
  list_report_t seen_report;
  list_report_t want_report;

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one operation to the model list and returns the report that the
  // block must give for it.
  function automatic list_report_t apply_list_op(input logic [OP_BITS-1:0] op,
                                                 input logic [31:0] word);
    list_report_t rep;
    int           i;
    bit           on_entry;
    rep = '0;
    rep.error_code = ERR_NONE;
    on_entry = list_cursor < list_count;
    case (op)
      OP_START: begin
        list_cursor = 0;
      end
      OP_ADVANCE: begin
        if (on_entry) list_cursor++;
      end
      OP_INSERT: begin
        if (list_count >= CAPACITY) begin
          rep.error_code = ERR_FULL;
        end else begin
          // Without a current entry the word goes to the front.
          if (!on_entry) list_cursor = 0;
          for (i = list_count; i > list_cursor; i--) list_words[i] = list_words[i-1];
          list_words[list_cursor] = word;
          list_count++;
        end
      end
      OP_ATTACH: begin
        if (list_count >= CAPACITY) begin
          rep.error_code = ERR_FULL;
        end else if (!on_entry) begin
          // Without a current entry the word goes to the end.
          list_cursor = list_count;
          list_words[list_cursor] = word;
          list_count++;
        end else begin
          for (i = list_count; i > list_cursor + 1; i--) list_words[i] = list_words[i-1];
          list_cursor++;
          list_words[list_cursor] = word;
          list_count++;
        end
      end
      OP_REMOVE: begin
        if (!on_entry) begin
          rep.error_code = ERR_NO_CUR;
        end else begin
          // Later entries close up; the one that followed becomes current.
          for (i = list_cursor; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
        end
      end
      default: begin
        // The unused codes leave everything as it is.
      end
    endcase
    if (list_cursor < list_count) begin
      rep.has_current = 1'b1;
      rep.current_word = list_words[list_cursor];
    end
    rep.entry_count = list_count[4:0];
    return rep;
  endfunction

  task automatic add_op(input logic [OP_BITS-1:0] op, input logic [31:0] word,
                        input logic hold = 1'b0);
    list_op_t item;
    item.op = op;
    item.word = word;
    item.hold = hold;
    op_queue.push_back(item);
  endtask

  // Counts a failure, and prints it while the count is still small.
  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  // Picks an operation whose mix depends on the phase. A small share of the
  // unused codes is mixed into every phase.
  function automatic logic [OP_BITS-1:0] pick_op(input phase_kind_t kind);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return OP_BITS'($urandom_range(7, 5));
    roll = $urandom_range(99);
    case (kind)
      PH_FILL: begin
        if (roll < 45) return OP_ATTACH;
        if (roll < 80) return OP_INSERT;
        if (roll < 90) return OP_ADVANCE;
        if (roll < 95) return OP_START;
        return OP_REMOVE;
      end
      PH_WALK: begin
        if (roll < 15) return OP_START;
        if (roll < 65) return OP_ADVANCE;
        if (roll < 77) return OP_REMOVE;
        if (roll < 89) return OP_INSERT;
        return OP_ATTACH;
      end
      default: begin
        if (roll < 50) return OP_REMOVE;
        if (roll < 70) return OP_START;
        if (roll < 90) return OP_ADVANCE;
        if (roll < 95) return OP_INSERT;
        return OP_ATTACH;
      end
    endcase
  endfunction

  // Stimulus and end of run. The whole queue is built up front; the driver
  // below then feeds it to the block at its own pace.
  initial begin
    phase_kind_t kind;
    int          counted;
    int          phase_len;
    int          n;
    logic [31:0] word;

    // Directed part: an empty list, both word extremes, stepping off the end,
    // ignored advances, insert and attach without a current entry, removing
    // the last entry and the unused operation codes.
    add_op(OP_REMOVE, 32'h0000_0000);
    add_op(OP_ADVANCE, 32'h1234_5678);
    add_op(OP_START, 32'h0000_0000);
    add_op(OP_INSERT, 32'h0000_0000);
    add_op(OP_ATTACH, 32'hFFFF_FFFF);
    add_op(OP_BITS'(5), 32'hFFFF_FFFF);
    add_op(OP_START, 32'h0000_0000);
    add_op(OP_ADVANCE, 32'h0000_0000);
    add_op(OP_ADVANCE, 32'h0000_0000);
    add_op(OP_ADVANCE, 32'h0000_0000);
    add_op(OP_REMOVE, 32'h0000_0000);
    add_op(OP_INSERT, 32'hA5A5_A5A5);
    add_op(OP_ADVANCE, 32'h0000_0000);
    add_op(OP_ADVANCE, 32'h0000_0000);
    add_op(OP_ADVANCE, 32'h0000_0000);
    add_op(OP_ATTACH, 32'h5A5A_5A5A);
    add_op(OP_REMOVE, 32'h0000_0000);
    add_op(OP_BITS'(6), 32'h8000_0001);
    add_op(OP_BITS'(7), 32'h7FFF_FFFE);
    add_op(OP_START, 32'h0000_0000);
    add_op(OP_REMOVE, 32'h0000_0000);

    // Random part in phases. The fill phases run the list into the full
    // error, the walk phases traverse it, the drain phases empty it. The first
    // operation of each phase waits until the block has caught up.
    counted = 0;
    n = 0;
    while (counted < RANDOM_OPS) begin
      kind = phase_kind_t'(n % 3);
      phase_len = $urandom_range(140, 60);
      for (int k = 0; k < phase_len && counted < RANDOM_OPS; k++) begin
        case ($urandom_range(9))
          0: word = 32'h0000_0000;
          1: word = 32'hFFFF_FFFF;
          default: word = $urandom;
        endcase
        add_op(pick_op(kind), word, k == 0);
        if (op_queue[op_queue.size()-1].op <= OP_REMOVE) counted++;
      end
      n++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (op_queue.size() != 0 || start || owed_reports.size() != 0) @(posedge clk);
    // A start operation can keep the block busy while a whole list rewinds,
    // so allow well over that for any stray strobe.
    repeat (CAPACITY * 3) @(posedge clk);

    if (fault_count == 0 && owed_reports.size() == 0) begin
      $display("** cursor_sequence_buffer_unit: PASSED **");
    end else begin
      $display("** cursor_sequence_buffer_unit: FAILED **");
    end
    $finish;
  end

  // Driver. Inputs change on the falling edge only. An operation stays on the
  // ports until a rising edge sees start high with busy low; after that the
  // sender either presents the next one or sits out a gap between bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took_op) begin
      // The block is still busy, so the operation is held as it is.
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
      in_op <= OP_BITS'($urandom);
      in_word_in <= $urandom;
    end else if (op_queue.size() == 0 || (op_queue[0].hold && owed_reports.size() != 0)) begin
      start <= 1'b0;
      in_op <= OP_BITS'($urandom);
      in_word_in <= $urandom;
    end else begin
      launch_op = op_queue.pop_front();
      start <= 1'b1;
      in_op <= launch_op.op;
      in_word_in <= launch_op.word;
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(40, 1);
        // About a third of the bursts run straight into the next one.
        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
      end
    end
  end

  // Monitor. On each rising edge a result strobe is checked against the
  // oldest owed report before a transfer at the same edge adds its own one.
  always @(posedge clk) begin
    if (!rst_n) begin
      took_op <= 1'b0;
    end else begin
      if (out_valid) begin
        seen_report.has_current = out_has_current;
        seen_report.current_word = out_current_word;
        seen_report.entry_count = out_entry_count;
        seen_report.error_code = out_error_code;
        if (owed_reports.size() == 0) begin
          log_fault($sformatf("unexpected result: cur=%0b word=%h count=%0d err=%0d",
                              out_has_current, out_current_word, out_entry_count,
                              out_error_code));
        end else begin
          want_report = owed_reports.pop_front();
          if (seen_report.has_current !== want_report.has_current ||
              seen_report.current_word !== want_report.current_word ||
              seen_report.entry_count !== want_report.entry_count ||
              seen_report.error_code !== want_report.error_code) begin
            log_fault($sformatf({"result %0d mismatch: expected cur=%0b word=%h count=%0d ",
                                 "err=%0d, got cur=%0b word=%h count=%0d err=%0d"},
                                report_index, want_report.has_current,
                                want_report.current_word, want_report.entry_count,
                                want_report.error_code, seen_report.has_current,
                                seen_report.current_word, seen_report.entry_count,
                                seen_report.error_code));
          end
        end
        report_index++;
      end
      took_op <= start && !busy;
      if (start && !busy) owed_reports.push_back(apply_list_op(in_op, in_word_in));
    end
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #3ms;
    $display("** cursor_sequence_buffer_unit: FAILED **");
    $finish;
  end

endmodule
